/* sv/sha256_pkg.sv */
package sha256_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  localparam logic FUNC_ABSORB = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [63:0] BLOCK_BITS = 64'd512;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

/* sv/sha256_byte_stream_hasher_core.sv */
// Absorb beat: stores its byte, and runs the 64 rounds and the add when it completes a block.
// Finish beat: pads byte by byte up to byte 55, then writes the length, then runs
// 64 rounds and the add per block (one extra block when over 55 bytes pend), then 8 out beats.
// Ready only in idle, so beats are taken one at a time; one shared round unit
// runs one round a cycle, and 16 word registers hold the block and the schedule.
// Async active-low reset loads the initial hash and clears fill and count.
module sha256_byte_stream_hasher_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sha256_pkg::in_beat_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sha256_pkg::out_beat_t out_data_o
);
  import sha256_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_ROUND = 6'b000100,
    ST_ADD   = 6'b001000,
    ST_OUT   = 6'b010000,
    ST_LEN   = 6'b100000
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [63:0] total_q;
  logic [5:0]  rnd_q;
  logic        fin_q;
  logic        lenblk_q;
  logic [2:0]  oidx_q;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] wt, t1, t2, s0, s1, ws;
  always_comb begin
    s1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
    s0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
    ws = s1 + w_q[9] + s0 + w_q[0];
    wt = w_q[0];
    t1 = v_q[7] + (ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + ROUND_K[rnd_q] + wt;
    t2 = (ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o.digest_word = h_q[oidx_q];
  assign out_data_o.word_index  = oidx_q;
  assign out_data_o.last_word   = (oidx_q == 3'd7);

  logic take;
  assign take = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (in_data_i.func == FUNC_FINISH) state_d = ST_PAD;
          else if (fill_q == 6'd63) state_d = ST_ROUND;
        end
      end
      ST_PAD: begin
        if (fill_q == 6'd55) state_d = ST_LEN;
        else if (fill_q == 6'd63) state_d = ST_ROUND;
      end
      ST_LEN:   state_d = ST_ROUND;
      ST_ROUND: if (rnd_q == 6'd63) state_d = ST_ADD;
      ST_ADD:   state_d = fin_q ? (lenblk_q ? ST_OUT : ST_PAD) : ST_IDLE;
      ST_OUT:   if (out_ready_i && oidx_q == 3'd7) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // first pad cycle sits at the pending byte count
  logic [31:0] w_d [16];
  logic [31:0] v_d [8];
  always_comb begin
    w_d = w_q;
    v_d = v_q;
    if (take && in_data_i.func == FUNC_ABSORB)
      w_d[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] = in_data_i.data_byte;
    if (state_q == ST_PAD)
      w_d[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] =
        (fill_q == total_q[8:3]) ? PAD_BYTE : 8'h00;
    if (state_q == ST_LEN) begin
      w_d[14] = total_q[63:32];
      w_d[15] = total_q[31:0];
    end
    if (state_q == ST_ROUND) begin
      for (int j = 0; j < 15; j++) w_d[j] = w_q[j + 1];
      w_d[15] = ws;
      for (int j = 7; j > 0; j--) v_d[j] = v_q[j - 1];
      v_d[4] = v_q[3] + t1;
      v_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      bits_q   <= '0;
      total_q  <= '0;
      rnd_q    <= '0;
      fin_q    <= 1'b0;
      lenblk_q <= 1'b0;
      oidx_q   <= '0;
      for (int j = 0; j < 8; j++) h_q[j] <= IV[j];
      for (int j = 0; j < 8; j++) v_q[j] <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (take) begin
            if (in_data_i.func == FUNC_FINISH) begin
              fin_q    <= 1'b1;
              lenblk_q <= 1'b0;
              total_q  <= bits_q + {55'd0, fill_q, 3'd0};
            end else begin
              fill_q <= fill_q + 6'd1;
              fin_q  <= 1'b0;
              if (fill_q == 6'd63) for (int j = 0; j < 8; j++) v_q[j] <= h_q[j];
            end
          end
        end
        ST_PAD: begin
          if (fill_q == 6'd55) begin
            fill_q <= '0;
          end else begin
            fill_q <= fill_q + 6'd1;
            if (fill_q == 6'd63) for (int j = 0; j < 8; j++) v_q[j] <= h_q[j];
          end
        end
        ST_LEN: begin
          lenblk_q <= 1'b1;
          for (int j = 0; j < 8; j++) v_q[j] <= h_q[j];
        end
        ST_ROUND: begin
          v_q   <= v_d;
          rnd_q <= rnd_q + 6'd1;
        end
        ST_ADD: begin
          for (int j = 0; j < 8; j++) h_q[j] <= h_q[j] + v_q[j];
          if (!fin_q) bits_q <= bits_q + BLOCK_BITS;
          oidx_q <= '0;
        end
        ST_OUT: begin
          if (out_ready_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              for (int j = 0; j < 8; j++) h_q[j] <= IV[j];
              fill_q <= '0;
              bits_q <= '0;
              fin_q  <= 1'b0;
              lenblk_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

endmodule
